FILE: rtl/psu_pkg.sv
// Shared types and constants of the PNG scanline unfilter.
// Register codes, filter codes, the handoff structs and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psu_pkg;

   localparam int MAX_ROW_BYTES_DEF   = 8192;
   localparam int MAX_PIXEL_BYTES_DEF = 4;

   localparam int BPP_W      = 3;
   localparam int RB_W       = 14;
   localparam int RT_W       = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [BPP_W-1:0] BPP_RST = 3'd4;
   localparam logic [RB_W-1:0]  RB_RST  = 14'd4;
   localparam logic [RT_W-1:0]  RT_RST  = 16'd1;

   localparam logic [7:0] ALPHA_FILL = 8'hFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BPP       = 8'd0,
      CSR_ROW_BYTES = 8'd1,
      CSR_ROW_TOTAL = 8'd2,
      CSR_EXPAND    = 8'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      FLT_NONE  = 3'd0,
      FLT_SUB   = 3'd1,
      FLT_UP    = 3'd2,
      FLT_AVG   = 3'd3,
      FLT_PAETH = 3'd4,
      FLT_BAD   = 3'd5
   } filter_code_type;

   typedef struct packed {
      logic [7:0]      data;
      filter_code_type filter;
      logic            first;
      logic            top_row;
      logic            row_end;
      logic            image_end;
      logic            alpha;
   } item_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic       alpha;
      logic       row_end;
      logic       image_end;
      logic       bad;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/psu_line_mem.sv
// Upper-row line store: one write port, one registered read port.
// A read of the address being written in the same cycle returns the new byte.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module psu_line_mem #(
   parameter int DEPTH = 8192,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/psu_seq.sv
// Row sequencer: filter byte decode, column and row counting, alpha cadence.
// Issues the line-store read for each data byte. Uses psu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psu_seq #(
   parameter int MAX_ROW_BYTES = psu_pkg::MAX_ROW_BYTES_DEF,
   localparam int AW = $clog2(MAX_ROW_BYTES)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [7:0]                  req_stream_byte,
   output logic                             req_stall,
   input  wire logic                        stage_busy,
   input  wire logic [psu_pkg::RB_W-1:0]    row_bytes,
   input  wire logic [psu_pkg::RT_W-1:0]    row_total,
   input  wire logic                        expand_rgb,
   output logic                             item_valid,
   output psu_pkg::item_type                item,
   output logic [AW-1:0]                    item_addr
);

   localparam int CW = $clog2(MAX_ROW_BYTES + 1);
   localparam int SW = (CW > psu_pkg::RB_W) ? CW : psu_pkg::RB_W;
   localparam logic [SW-1:0] RB_LIMIT = SW'(MAX_ROW_BYTES);

   logic [CW-1:0]                 column_ff, column_in;
   logic [psu_pkg::RT_W-1:0]      row_index_ff, row_index_in;
   psu_pkg::filter_code_type      filter_ff, filter_in;
   logic [1:0]                    chan_ff, chan_in;

   logic [SW-1:0]                 rb_wide;
   logic [CW-1:0]                 rb_sat;
   logic [CW-1:0]                 idx_wide;
   logic [psu_pkg::RT_W-1:0]      rt_eff;
   logic [psu_pkg::RT_W:0]        row_next;
   logic                          data_phase, accept, row_done, img_done, alpha;

   assign data_phase = (column_ff != '0);
   assign req_stall  = data_phase && stage_busy;
   assign accept     = req_valid && !req_stall;

   always_comb begin
      rb_wide  = SW'(row_bytes);
      rb_sat   = (rb_wide == '0) ? CW'(1) :
                 (rb_wide > RB_LIMIT) ? CW'(MAX_ROW_BYTES) : rb_wide[CW-1:0];
      rt_eff   = (row_total == '0) ? psu_pkg::RT_W'(1) : row_total;
      row_next = {1'b0, row_index_ff} + (psu_pkg::RT_W + 1)'(1);
      row_done = (column_ff >= rb_sat);
      img_done = row_done && (row_next >= {1'b0, rt_eff});
      idx_wide = column_ff - CW'(1);

      column_in    = column_ff;
      row_index_in = row_index_ff;
      filter_in    = filter_ff;
      chan_in      = chan_ff;
      alpha        = 1'b0;

      if (accept) begin
         if (!data_phase) begin
            filter_in = (req_stream_byte <= 8'(psu_pkg::FLT_PAETH)) ?
                        psu_pkg::filter_code_type'(req_stream_byte[2:0]) :
                        psu_pkg::FLT_BAD;
            column_in = CW'(1);
         end else begin
            if (row_done) begin
               column_in    = '0;
               row_index_in = img_done ? '0 : row_next[psu_pkg::RT_W-1:0];
            end else begin
               column_in = column_ff + CW'(1);
            end
            if (expand_rgb) begin
               if (chan_ff >= 2'd2) begin
                  alpha   = 1'b1;
                  chan_in = 2'd0;
               end else begin
                  chan_in = chan_ff + 2'd1;
               end
            end else begin
               chan_in = 2'd0;
            end
            if (img_done) begin
               chan_in = 2'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         row_index_ff <= '0;
         filter_ff    <= psu_pkg::FLT_NONE;
         chan_ff      <= 2'd0;
      end else begin
         column_ff    <= column_in;
         row_index_ff <= row_index_in;
         filter_ff    <= filter_in;
         chan_ff      <= chan_in;
      end
   end

   assign item_valid     = accept && data_phase;
   assign item_addr      = idx_wide[AW-1:0];
   assign item.data      = req_stream_byte;
   assign item.filter    = filter_ff;
   assign item.first     = (column_ff == CW'(1));
   assign item.top_row   = (row_index_ff == '0);
   assign item.row_end   = row_done;
   assign item.image_end = img_done;
   assign item.alpha     = alpha;

endmodule

`default_nettype wire

FILE: rtl/psu_recon.sv
// Reconstruction stage: takes the upper byte from the line store, applies the
// row's filter against the left history and writes the result back. Uses psu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psu_recon #(
   parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF,
   localparam int AW = $clog2(MAX_ROW_BYTES)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        item_valid,
   input  wire psu_pkg::item_type           item,
   input  wire logic [AW-1:0]               item_addr,
   output logic                             busy,
   input  wire logic [psu_pkg::BPP_W-1:0]   bytes_per_pixel,
   input  wire logic [7:0]                  rd_data,
   output logic                             wr_en,
   output logic [AW-1:0]                    wr_addr,
   output logic [7:0]                       wr_data,
   output logic                             res_valid,
   output psu_pkg::result_type              res,
   input  wire logic                        res_ready
);

   localparam int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
   localparam logic [psu_pkg::BPP_W:0] BPP_LIMIT = (psu_pkg::BPP_W + 1)'(MAX_PIXEL_BYTES);

   logic                  s1_valid_ff;
   psu_pkg::item_type     item_ff;
   logic [AW-1:0]         addr_ff;
   logic [7:0]            left_ff [MAX_PIXEL_BYTES];
   logic [7:0]            ul_ff   [MAX_PIXEL_BYTES];
   logic [7:0]            left_in [MAX_PIXEL_BYTES];
   logic [7:0]            ul_in   [MAX_PIXEL_BYTES];

   logic [psu_pkg::BPP_W:0] bpp_wide, bpp_sat, tap_wide;
   logic [HW-1:0]           tap;
   logic [7:0]              a, b, c, pred, recon;
   logic [8:0]              sum_ab;
   logic [9:0]              d_a, d_b, d_c, pa, pb, pc;
   logic                    adv, bad;

   assign adv  = s1_valid_ff && res_ready;
   assign busy = s1_valid_ff && !res_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= item_valid || busy;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid) begin
         item_ff <= item;
         addr_ff <= item_addr;
      end
   end

   always_comb begin
      bpp_wide = {1'b0, bytes_per_pixel};
      bpp_sat  = (bpp_wide == '0) ? (psu_pkg::BPP_W + 1)'(1) :
                 (bpp_wide > BPP_LIMIT) ? BPP_LIMIT : bpp_wide;
      tap_wide = bpp_sat - (psu_pkg::BPP_W + 1)'(1);
      tap      = tap_wide[HW-1:0];

      bad = (item_ff.filter == psu_pkg::FLT_BAD);
      a   = item_ff.first   ? 8'd0 : left_ff[tap];
      c   = item_ff.first   ? 8'd0 : ul_ff[tap];
      b   = item_ff.top_row ? 8'd0 : rd_data;

      sum_ab = {1'b0, a} + {1'b0, b};
      d_a    = {2'b0, b} - {2'b0, c};
      d_b    = {2'b0, a} - {2'b0, c};
      d_c    = {1'b0, sum_ab} - {1'b0, c, 1'b0};
      pa     = d_a[9] ? (10'd0 - d_a) : d_a;
      pb     = d_b[9] ? (10'd0 - d_b) : d_b;
      pc     = d_c[9] ? (10'd0 - d_c) : d_c;

      case (item_ff.filter)
         psu_pkg::FLT_SUB:   pred = a;
         psu_pkg::FLT_UP:    pred = b;
         psu_pkg::FLT_AVG:   pred = sum_ab[8:1];
         psu_pkg::FLT_PAETH: begin
            if (pa <= pb && pa <= pc) begin
               pred = a;
            end else if (pb <= pc) begin
               pred = b;
            end else begin
               pred = c;
            end
         end
         default:            pred = 8'd0;
      endcase

      recon = bad ? 8'd0 : (item_ff.data + pred);

      left_in[0] = recon;
      ul_in[0]   = b;
      for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
         left_in[k] = item_ff.first ? 8'd0 : left_ff[k-1];
         ul_in[k]   = item_ff.first ? 8'd0 : ul_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            left_ff[k] <= left_in[k];
            ul_ff[k]   <= ul_in[k];
         end
      end
   end

   assign wr_en   = adv;
   assign wr_addr = addr_ff;
   assign wr_data = recon;

   assign res_valid     = adv;
   assign res.pixel     = recon;
   assign res.alpha     = item_ff.alpha;
   assign res.row_end   = item_ff.row_end;
   assign res.image_end = item_ff.image_end;
   assign res.bad       = bad;

endmodule

`default_nettype wire

FILE: rtl/psu_out.sv
// Result register: presents a reconstructed byte, then its alpha fill beat
// when one is due. Uses psu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psu_out (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 take_valid,
   input  wire psu_pkg::result_type  take,
   output logic                      ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [7:0]                rsp_pixel_byte,
   output logic                      rsp_run_last,
   output logic                      rsp_row_end,
   output logic                      rsp_image_end,
   output logic                      rsp_bad_filter
);

   logic                valid_ff;
   logic                phase_ff;
   psu_pkg::result_type res_ff;
   logic                last_beat, done;

   assign last_beat = phase_ff || !res_ff.alpha;
   assign done      = valid_ff && !rsp_stall && last_beat;
   assign ready     = !valid_ff || done;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else if (take_valid) begin
         valid_ff <= 1'b1;
         phase_ff <= 1'b0;
      end else if (done) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else if (valid_ff && !rsp_stall) begin
         phase_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take_valid) begin
         res_ff <= take;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_pixel_byte = phase_ff ? psu_pkg::ALPHA_FILL : res_ff.pixel;
   assign rsp_run_last   = last_beat;
   assign rsp_row_end    = last_beat && res_ff.row_end;
   assign rsp_image_end  = last_beat && res_ff.image_end;
   assign rsp_bad_filter = res_ff.bad;

endmodule

`default_nettype wire

FILE: rtl/png_scanline_unfilter.sv
// PNG scanline unfilter for 8-bit images, top level.
// Holds the registers and joins sequencer, line store, reconstruction and
// result register. Uses psu_pkg and all psu_ modules.
//
// Feed the inflated stream on req_: each row is a filter-type byte, then
// row_bytes data bytes. A filter byte yields no beat; a data byte yields one
// rsp_ beat, or two when an alpha fill of 255 follows it (expand_rgb set).
// A data byte taken on req_ passes the registered upper-row read, then
// reconstruction into the result register, before it reaches rsp_valid.
// One byte is taken every cycle while the receiver keeps up and no alpha
// fill is due; a byte with an alpha fill holds the result register for its
// fill beat as well. The per-byte rate is set by the read-modify-write of
// the line store, whose same-address read is forwarded from the write port.
// When rsp_stall is high the result register holds its beat, the
// reconstruction stage holds one more byte, and req_stall rises for data
// bytes; filter bytes are still taken.
// Reset clears the counters and the registers to their defaults; the line
// store is not cleared and needs no time after reset. Registers are
// written on csr_ only while no byte is in flight; the user must ensure it.
`timescale 1ns / 1ps
`default_nettype none

module png_scanline_unfilter #(
   parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [7:0]                       req_stream_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [7:0]                            rsp_pixel_byte,
   output logic                                  rsp_run_last,
   output logic                                  rsp_row_end,
   output logic                                  rsp_image_end,
   output logic                                  rsp_bad_filter,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [psu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [psu_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int AW = $clog2(MAX_ROW_BYTES);

   logic [psu_pkg::BPP_W-1:0] bpp_ff;
   logic [psu_pkg::RB_W-1:0]  row_bytes_ff;
   logic [psu_pkg::RT_W-1:0]  row_total_ff;
   logic                      expand_ff;

   logic                      item_valid, stage_busy;
   psu_pkg::item_type         item;
   logic [AW-1:0]             item_addr;
   logic [7:0]                rd_data;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [7:0]                wr_data;
   logic                      res_valid, res_ready;
   psu_pkg::result_type       res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff       <= psu_pkg::BPP_RST;
         row_bytes_ff <= psu_pkg::RB_RST;
         row_total_ff <= psu_pkg::RT_RST;
         expand_ff    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (psu_pkg::csr_index_type'(csr_index))
            psu_pkg::CSR_BPP:       bpp_ff       <= csr_wdata[psu_pkg::BPP_W-1:0];
            psu_pkg::CSR_ROW_BYTES: row_bytes_ff <= csr_wdata[psu_pkg::RB_W-1:0];
            psu_pkg::CSR_ROW_TOTAL: row_total_ff <= csr_wdata[psu_pkg::RT_W-1:0];
            psu_pkg::CSR_EXPAND:    expand_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   psu_seq #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stream_byte (req_stream_byte),
      .req_stall       (req_stall),
      .stage_busy      (stage_busy),
      .row_bytes       (row_bytes_ff),
      .row_total       (row_total_ff),
      .expand_rgb      (expand_ff),
      .item_valid      (item_valid),
      .item            (item),
      .item_addr       (item_addr)
   );

   psu_line_mem #(
      .DEPTH (MAX_ROW_BYTES)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (item_valid),
      .rd_addr (item_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   psu_recon #(
      .MAX_ROW_BYTES   (MAX_ROW_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_recon (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item            (item),
      .item_addr       (item_addr),
      .busy            (stage_busy),
      .bytes_per_pixel (bpp_ff),
      .rd_data         (rd_data),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .res_valid       (res_valid),
      .res             (res),
      .res_ready       (res_ready)
   );

   psu_out u_out (
      .clock          (clock),
      .reset          (reset),
      .take_valid     (res_valid),
      .take           (res),
      .ready          (res_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_byte (rsp_pixel_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_row_end    (rsp_row_end),
      .rsp_image_end  (rsp_image_end),
      .rsp_bad_filter (rsp_bad_filter)
   );

   a_alpha_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=>
         rsp_valid && rsp_run_last && (rsp_pixel_byte == psu_pkg::ALPHA_FILL))
      else $error("alpha fill beat missing after a non-final beat");

   a_image_ends_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_end |-> rsp_row_end && rsp_run_last)
      else $error("image end without row end");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat straight after reset");

   a_write_on_take: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> res_ready)
      else $error("line store written while the result register is full");

endmodule

`default_nettype wire

FILE: bench/png_scanline_unfilter_checker.sv
// Scoreboard for png_scanline_unfilter: watches the req_, rsp_ and csr_ beats,
// rebuilds every scanline itself and checks each rsp_ beat field by field.
// Depends on psu_pkg.
`timescale 1ns / 1ps

module png_scanline_unfilter_checker
   import psu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [7:0]            req_stream_byte,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic [7:0]            rsp_pixel_byte,
   input  wire logic                  rsp_run_last,
   input  wire logic                  rsp_row_end,
   input  wire logic                  rsp_image_end,
   input  wire logic                  rsp_bad_filter,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         pending_beats
);

   typedef struct packed {
      logic [7:0] pixel;
      logic       run_last;
      logic       row_end;
      logic       image_end;
      logic       bad;
   } pixel_beat_type;

   pixel_beat_type   due_beats [$];

   logic [BPP_W-1:0] bpp_reg;
   logic [RB_W-1:0]  rb_reg;
   logic [RT_W-1:0]  rt_reg;
   logic             expand_reg;

   int               col_pos;
   int               row_pos;
   int               alpha_phase;
   filter_code_type  row_filter;
   logic [7:0]       upper_row [MAX_ROW_BYTES_DEF];
   logic [7:0]       left_bytes [MAX_PIXEL_BYTES_DEF];
   logic [7:0]       upper_left_bytes [MAX_PIXEL_BYTES_DEF];

   initial begin
      fail_count = 0;
      pending_beats = 0;
   end

   task automatic flag_mismatch(input string msg);
      $display("%0t ns  rsp_ mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic unfilter_byte(input logic [7:0] x);
      int         bpp;
      int         rb;
      int         rt;
      int         idx;
      int         a;
      int         b;
      int         c;
      int         pred;
      int         p;
      int         pa;
      int         pb;
      int         pc;
      int         k;
      logic [7:0] recon;
      logic       bad;
      logic       row_done;
      logic       img_done;
      logic       alpha;
      bpp = (bpp_reg < 1) ? 1 :
            ((bpp_reg > MAX_PIXEL_BYTES_DEF) ? MAX_PIXEL_BYTES_DEF : int'(bpp_reg));
      rb = (rb_reg < 1) ? 1 : ((rb_reg > MAX_ROW_BYTES_DEF) ? MAX_ROW_BYTES_DEF : int'(rb_reg));
      rt = (rt_reg == 0) ? 1 : int'(rt_reg);

      if (col_pos == 0) begin
         row_filter = (x <= 8'(FLT_PAETH)) ? filter_code_type'(x[2:0]) : FLT_BAD;
         foreach (left_bytes[i]) begin
            left_bytes[i] = 8'h00;
            upper_left_bytes[i] = 8'h00;
         end
         col_pos = 1;
         return;
      end

      idx = (col_pos - 1 >= MAX_ROW_BYTES_DEF) ? MAX_ROW_BYTES_DEF - 1 : col_pos - 1;
      bad = (row_filter == FLT_BAD);
      a = left_bytes[bpp - 1];
      b = (row_pos == 0) ? 0 : upper_row[idx];
      c = upper_left_bytes[bpp - 1];

      case (row_filter)
         FLT_SUB:   pred = a;
         FLT_UP:    pred = b;
         FLT_AVG:   pred = (a + b) >> 1;
         FLT_PAETH: begin
            p = a + b - c;
            pa = (p > a) ? p - a : a - p;
            pb = (p > b) ? p - b : b - p;
            pc = (p > c) ? p - c : c - p;
            if (pa <= pb && pa <= pc) pred = a;
            else if (pb <= pc) pred = b;
            else pred = c;
         end
         default:   pred = 0;
      endcase
      recon = bad ? 8'h00 : 8'(int'(x) + pred);

      for (k = MAX_PIXEL_BYTES_DEF - 1; k > 0; k--) begin
         left_bytes[k] = left_bytes[k - 1];
         upper_left_bytes[k] = upper_left_bytes[k - 1];
      end
      left_bytes[0] = recon;
      upper_left_bytes[0] = 8'(b);
      upper_row[idx] = recon;

      row_done = (col_pos >= rb);
      img_done = row_done && (row_pos + 1 >= rt);
      if (row_done) begin
         col_pos = 0;
         row_pos = img_done ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end

      alpha = 1'b0;
      if (expand_reg) begin
         if (alpha_phase >= 2) begin
            alpha = 1'b1;
            alpha_phase = 0;
         end else begin
            alpha_phase++;
         end
      end else begin
         alpha_phase = 0;
      end
      if (img_done) alpha_phase = 0;

      if (alpha) begin
         due_beats.push_back(pixel_beat_type'{recon, 1'b0, 1'b0, 1'b0, bad});
         due_beats.push_back(pixel_beat_type'{ALPHA_FILL, 1'b1, row_done, img_done, bad});
      end else begin
         due_beats.push_back(pixel_beat_type'{recon, 1'b1, row_done, img_done, bad});
      end
   endtask

   task automatic check_beat();
      pixel_beat_type want;
      if (due_beats.size() == 0) begin
         flag_mismatch($sformatf("beat with nothing due, pixel_byte %h", rsp_pixel_byte));
         return;
      end
      want = due_beats.pop_front();
      if (rsp_pixel_byte !== want.pixel)
         flag_mismatch($sformatf("pixel_byte %h, want %h", rsp_pixel_byte, want.pixel));
      if (rsp_run_last !== want.run_last)
         flag_mismatch($sformatf("run_last %b, want %b", rsp_run_last, want.run_last));
      if (rsp_row_end !== want.row_end)
         flag_mismatch($sformatf("row_end %b, want %b", rsp_row_end, want.row_end));
      if (rsp_image_end !== want.image_end)
         flag_mismatch($sformatf("image_end %b, want %b", rsp_image_end, want.image_end));
      if (rsp_bad_filter !== want.bad)
         flag_mismatch($sformatf("bad_filter %b, want %b", rsp_bad_filter, want.bad));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         bpp_reg = BPP_RST;
         rb_reg = RB_RST;
         rt_reg = RT_RST;
         expand_reg = 1'b0;
         col_pos = 0;
         row_pos = 0;
         alpha_phase = 0;
         row_filter = FLT_NONE;
         foreach (left_bytes[i]) begin
            left_bytes[i] = 8'h00;
            upper_left_bytes[i] = 8'h00;
         end
         due_beats.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BPP:       bpp_reg = csr_wdata[BPP_W-1:0];
               CSR_ROW_BYTES: rb_reg = csr_wdata[RB_W-1:0];
               CSR_ROW_TOTAL: rt_reg = csr_wdata[RT_W-1:0];
               CSR_EXPAND:    expand_reg = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) unfilter_byte(req_stream_byte);
         if (rsp_valid && !rsp_stall) check_beat();
      end
      pending_beats = due_beats.size();
   end

endmodule

FILE: bench/png_scanline_unfilter_tb.sv
// Top of the png_scanline_unfilter regression: clock, reset, byte stimulus,
// random back-pressure and register phases; the verdict comes from the
// counts handed up by png_scanline_unfilter_checker. Depends on psu_pkg.
`timescale 1ns / 1ps

module png_scanline_unfilter_tb;
   import psu_pkg::*;

   localparam longint TIMEOUT_NS   = 64'd12_000_000;
   localparam int     RANDOM_BYTES = 880;
   localparam int     HOLD_CYCLES  = 150;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_stream_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [7:0]            rsp_pixel_byte;
   logic                  rsp_run_last;
   logic                  rsp_row_end;
   logic                  rsp_image_end;
   logic                  rsp_bad_filter;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int                    fail_count;
   int                    pending_beats;

   bit                    quiet = 1'b0;
   int                    hold_ticket = 0;
   int                    hold_seen = 0;
   int                    hold_left = 0;
   int                    stall_left = 0;

   logic [RB_W-1:0]       rb_set = RB_RST;
   logic [RT_W-1:0]       rt_set = RT_RST;
   int                    trk_col = 0;
   int                    trk_row = 0;
   int                    span = 0;
   int                    bytes_sent = 0;

   png_scanline_unfilter u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_byte  (rsp_pixel_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_row_end     (rsp_row_end),
      .rsp_image_end   (rsp_image_end),
      .rsp_bad_filter  (rsp_bad_filter),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   png_scanline_unfilter_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_byte  (rsp_pixel_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_row_end     (rsp_row_end),
      .rsp_image_end   (rsp_image_end),
      .rsp_bad_filter  (rsp_bad_filter),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_beats   (pending_beats)
   );

   always #6 clock = ~clock;

   // receiver: random stall after each beat, plus a long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
         end
         if (rsp_valid && !rsp_stall) stall_left = quiet ? 0 : $urandom_range(0, 7);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_byte(input logic [7:0] value);
      int gap;
      int rb_eff;
      int rt_eff;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_stream_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      // follow the row framing so register changes never read an unwritten line entry
      if (trk_col == 0) begin
         trk_col = 1;
      end else begin
         rb_eff = (rb_set == 0) ? 1 :
                  ((rb_set > MAX_ROW_BYTES_DEF) ? MAX_ROW_BYTES_DEF : int'(rb_set));
         rt_eff = (rt_set == 0) ? 1 : int'(rt_set);
         if (trk_col > span) span = (trk_col > MAX_ROW_BYTES_DEF) ? MAX_ROW_BYTES_DEF : trk_col;
         if (trk_col >= rb_eff) begin
            trk_col = 0;
            trk_row = (trk_row + 1 >= rt_eff) ? 0 : trk_row + 1;
         end else begin
            trk_col++;
         end
      end
   endtask

   task automatic send_next();
      logic [7:0] value;
      if (trk_col == 0) begin
         if ($urandom_range(0, 9) != 0) value = 8'($urandom_range(FLT_NONE, FLT_PAETH));
         else value = 8'($urandom_range(FLT_BAD, 255));
      end else if ($urandom_range(0, 7) == 0) begin
         value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
         value = 8'($urandom);
      end
      send_byte(value);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_ROW_BYTES: rb_set = value[RB_W-1:0];
         CSR_ROW_TOTAL: rt_set = value[RT_W-1:0];
         default: ;
      endcase
   endtask

   // drain to idle, then rewrite the selected registers
   task automatic begin_phase(input bit calm, input logic [3:0] mask,
                              input logic [CSR_DATA_W-1:0] bpp,
                              input logic [CSR_DATA_W-1:0] rb,
                              input logic [CSR_DATA_W-1:0] rt,
                              input logic [CSR_DATA_W-1:0] expand);
      req_valid <= 1'b0;
      quiet <= calm;
      @(negedge clock);
      while (pending_beats != 0) @(negedge clock);
      repeat (4) @(posedge clock);
      if (mask[CSR_BPP]) write_reg(CSR_BPP, bpp);
      if (mask[CSR_ROW_BYTES]) write_reg(CSR_ROW_BYTES, rb);
      if (mask[CSR_ROW_TOTAL]) write_reg(CSR_ROW_TOTAL, rt);
      if (mask[CSR_EXPAND]) write_reg(CSR_EXPAND, expand);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [7:0]            tour [20] = '{
         8'(FLT_SUB),   8'hFF, 8'h01, 8'h80,
         8'(FLT_UP),    8'h01, 8'hFF, 8'h7F,
         8'(FLT_AVG),   8'hFF, 8'hFF, 8'h01,
         8'(FLT_PAETH), 8'h00, 8'hFF, 8'h80,
         8'hFF,         8'h12, 8'h34, 8'h56
      };
      int                    first_random;
      int                    phase;
      int                    rows;
      int                    n;
      bit                    calm;
      logic [3:0]            mask;
      logic [CSR_DATA_W-1:0] rb_pick;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: four bytes per pixel, four-byte rows, one-row images
      send_byte(8'(FLT_NONE));
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h7F);

      // Sub, Up, Average, Paeth, unknown; stacked so Up, Average and Paeth see a row above
      begin_phase(1'b0, 4'hF, 16'd1, 16'd3, 16'd5, 16'd1);
      foreach (tour[i]) send_byte(tour[i]);

      // saturating row length, tallest image, zero pixel width; stop mid-row
      begin_phase(1'b0, 4'hF, 16'd0, 16'h3FFF, 16'hFFFF, 16'd0);
      repeat (41) send_next();

      first_random = bytes_sent;
      phase = 0;
      while (bytes_sent - first_random < RANDOM_BYTES) begin
         calm = (phase % 5 == 2) || ($urandom_range(0, 3) == 0);
         mask = 4'($urandom_range(1, 15));
         if (rb_set > 64) mask[CSR_ROW_BYTES] = 1'b1;
         rb_pick = 16'($urandom_range(0, 24));
         if (trk_row != 0 && rb_pick > span) rb_pick = 16'(span);
         begin_phase(calm, mask, 16'($urandom_range(0, 7)), rb_pick,
                     ($urandom_range(0, 11) == 0) ? 16'hFFFF : 16'($urandom_range(0, 6)),
                     16'($urandom_range(0, 1)));
         if (phase % 5 == 2) hold_ticket <= hold_ticket + 1;
         rows = $urandom_range(1, 8);
         repeat (rows) begin
            send_next();
            while (trk_col != 0) send_next();
         end
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_next();
         phase++;
      end

      req_valid <= 1'b0;
      for (n = 0; n < 5000 && pending_beats != 0; n++) @(negedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_beats == 0) begin
         $display("png_scanline_unfilter regression: pass");
      end else begin
         if (pending_beats != 0) $display("%0d rsp_ beats never arrived", pending_beats);
         $display("png_scanline_unfilter regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("timeout after %0d ns", TIMEOUT_NS);
      $display("png_scanline_unfilter regression: fail");
      $finish;
   end

endmodule

FILE: files.f
rtl/psu_pkg.sv
rtl/psu_line_mem.sv
rtl/psu_seq.sv
rtl/psu_recon.sv
rtl/psu_out.sv
rtl/png_scanline_unfilter.sv
bench/png_scanline_unfilter_checker.sv
bench/png_scanline_unfilter_tb.sv
